// ===== hdl/efcu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efcu_pkg: Fly-camera pose tracker package
// Operation codes, angle constants, the arctangent table and the command and
// status types shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package efcu_pkg;

    typedef enum logic [1:0] {
        OP_MOVE = 2'd0,
        OP_LOOK = 2'd1,
        OP_SET  = 2'd2
    } op_t;

    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_BACK  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic CFG_MOVE_SPEED  = 1'b0;
    localparam logic CFG_SENSITIVITY = 1'b1;

    localparam logic [16:0] YAW_FULL  = 17'd92160;
    localparam int          PITCH_LIM = 22784;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
    localparam logic signed [25:0] DEG90  = 26'sd5898240;
    localparam logic signed [25:0] DEG180 = 26'sd11796480;
    localparam logic signed [25:0] DEG270 = 26'sd17694720;
    localparam logic signed [25:0] DEG360 = 26'sd23592960;
    localparam logic signed [15:0] UNIT   = 16'sd16384;
    localparam int ATAN_COUNT = 24;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCALE,
        CMD_WRAP,
        CMD_CORDIC_INIT,
        CMD_CORDIC_STEP,
        CMD_CORDIC_DONE,
        CMD_BUILD
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
        logic      second;
        logic      wr_move;
        logic      wr_set;
        logic      wr_look;
    } dp_cmd_t;

    typedef struct packed {
        logic wrap_busy;
        logic cordic_last;
    } dp_status_t;

    function automatic logic signed [22:0] atan_deg16(input logic [4:0] i);
        logic signed [22:0] r;
        begin
            case (i)
                5'd0:  r = 23'sd2949120;
                5'd1:  r = 23'sd1740967;
                5'd2:  r = 23'sd919879;
                5'd3:  r = 23'sd466945;
                5'd4:  r = 23'sd234379;
                5'd5:  r = 23'sd117304;
                5'd6:  r = 23'sd58666;
                5'd7:  r = 23'sd29335;
                5'd8:  r = 23'sd14668;
                5'd9:  r = 23'sd7334;
                5'd10: r = 23'sd3667;
                5'd11: r = 23'sd1833;
                5'd12: r = 23'sd917;
                5'd13: r = 23'sd458;
                5'd14: r = 23'sd229;
                5'd15: r = 23'sd115;
                5'd16: r = 23'sd57;
                5'd17: r = 23'sd29;
                5'd18: r = 23'sd14;
                5'd19: r = 23'sd7;
                5'd20: r = 23'sd4;
                5'd21: r = 23'sd2;
                5'd22: r = 23'sd1;
                default: r = 23'sd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/efcu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efcu_datapath: Fly-camera pose datapath
// Holds the pose, scales offsets, wraps yaw, runs a shared iterative CORDIC
// and steps the position one axis per cycle with saturation.
// ----------------------------------------------------------------------------
module efcu_datapath #(
    parameter int CORDIC_STEPS  = 16,
    parameter int POS_FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire efcu_pkg::dp_cmd_t  cmd,
    output efcu_pkg::dp_status_t    status,
    input  wire logic               cfg_we,
    input  wire logic               cfg_idx,
    input  wire logic [15:0]        cfg_data,
    input  wire logic [1:0]         move_direction,
    input  wire logic [15:0]        delta_time,
    input  wire logic signed [15:0] look_dx,
    input  wire logic signed [15:0] look_dy,
    input  wire logic signed [31:0] new_x,
    input  wire logic signed [31:0] new_y,
    input  wire logic signed [31:0] new_z,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      pos_z,
    output logic signed [15:0]      fwd_x,
    output logic signed [15:0]      fwd_y,
    output logic signed [15:0]      fwd_z,
    output logic signed [15:0]      side_x,
    output logic signed [15:0]      side_z,
    output logic signed [15:0]      pitch_deg,
    output logic [16:0]             yaw_deg
);

    localparam int STEP_W  = (CORDIC_STEPS < efcu_pkg::ATAN_COUNT) ?
                             CORDIC_STEPS : efcu_pkg::ATAN_COUNT;
    localparam int SH      = 38 - POS_FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (SH - 1);

    logic [15:0] speed_reg, sens_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [15:0] fx_reg, fy_reg, fz_reg, sx_reg, sz_reg, pitch_reg;
    logic [16:0] yaw_reg;

    logic [1:0]  dir_reg;
    logic [15:0] dt_reg;
    logic signed [15:0] dx_in_reg, dy_in_reg;
    logic [31:0] scale_reg;
    logic signed [25:0] wyaw_reg;
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [25:0] cz_reg;
    logic [4:0]  it_reg;
    logic        neg_reg;
    logic signed [15:0] sp_reg, cp_reg, sy_reg, cy2_reg;
    logic [1:0]  axis_reg;
    logic [1:0]  bstep_reg;
    logic signed [31:0] prod_reg;

    logic signed [32:0] dxm, dym;
    logic signed [24:0] dxr, dyr;
    logic signed [33:0] shx, shy;
    logic signed [15:0] rs, rc;
    logic signed [25:0] pang, yang;
    logic signed [48:0] mv;
    logic signed [63:0] mvr;
    logic signed [33:0] newp;
    logic signed [31:0] cur_p, sat_p;
    logic signed [15:0] comp;
    logic sub;

    function automatic logic signed [15:0] rnd_clamp(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [18:0] q;
        begin
            t = {v[33], v} + 35'sd32768;
            q = t[34:16];
            if (q > 19'sd16384) return 16'sd16384;
            if (q < -19'sd16384) return -16'sd16384;
            return q[15:0];
        end
    endfunction

    assign dxm = dx_in_reg * $signed({1'b0, sens_reg});
    assign dym = dy_in_reg * $signed({1'b0, sens_reg});
    assign dxr = 25'(((dxm + 33'sd128) >>> 8));
    assign dyr = 25'(((dym + 33'sd128) >>> 8));

    assign shx = cy_reg >>> it_reg;
    assign shy = cx_reg >>> it_reg;
    assign rs = rnd_clamp(cy_reg);
    assign rc = rnd_clamp(cx_reg);
    assign pang = 26'(pitch_reg) <<< 8;
    assign yang = $signed({1'b0, yaw_reg, 8'd0});

    always_comb
    begin
        case (axis_reg)
            2'd0: cur_p = px_reg;
            2'd1: cur_p = py_reg;
            default: cur_p = pz_reg;
        endcase
        if (dir_reg[1]) begin
            comp = (axis_reg == 2'd0) ? sx_reg : sz_reg;
            sub = (dir_reg == efcu_pkg::DIR_LEFT);
        end else begin
            case (axis_reg)
                2'd0: comp = fx_reg;
                2'd1: comp = fy_reg;
                default: comp = fz_reg;
            endcase
            sub = (dir_reg == efcu_pkg::DIR_BACK);
        end
    end

    assign mv = $signed({1'b0, scale_reg}) * comp;
    assign mvr = (64'(mv) + HALF) >>> SH;
    assign newp = sub ? (34'(cur_p) - 34'(mvr)) : (34'(cur_p) + 34'(mvr));
    assign sat_p = (newp > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                   (newp < -34'sh080000000) ? -32'sh80000000 : newp[31:0];

    assign status.wrap_busy   = (wyaw_reg < 26'sd0) || (wyaw_reg >= 26'(efcu_pkg::YAW_FULL));
    assign status.cordic_last = (32'(it_reg) == STEP_W - 1) || (STEP_W == 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            speed_reg <= 16'd768;
            sens_reg  <= 16'd3277;
            px_reg <= '0; py_reg <= '0; pz_reg <= '0;
            fx_reg <= '0; fy_reg <= '0; fz_reg <= -efcu_pkg::UNIT;
            sx_reg <= efcu_pkg::UNIT; sz_reg <= '0;
            pitch_reg <= '0; yaw_reg <= '0;
            axis_reg <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_idx == efcu_pkg::CFG_MOVE_SPEED) speed_reg <= cfg_data;
                else sens_reg <= cfg_data;
            end
            case (cmd.code)
                efcu_pkg::CMD_LOAD:
                begin
                    dir_reg <= move_direction; dt_reg <= delta_time;
                    dx_in_reg <= look_dx; dy_in_reg <= look_dy;
                    axis_reg <= 2'd0;
                    if (cmd.wr_set) begin
                        px_reg <= new_x; py_reg <= new_y; pz_reg <= new_z;
                    end
                end
                efcu_pkg::CMD_SCALE:
                begin
                    scale_reg <= speed_reg * dt_reg;
                    wyaw_reg <= 26'($signed({1'b0, yaw_reg})) - 26'(dxr);
                    if (cmd.wr_look) begin
                        if (32'(pitch_reg) + 32'(dyr) > efcu_pkg::PITCH_LIM)
                            pitch_reg <= 16'(efcu_pkg::PITCH_LIM);
                        else if (32'(pitch_reg) + 32'(dyr) < -efcu_pkg::PITCH_LIM)
                            pitch_reg <= -16'(efcu_pkg::PITCH_LIM);
                        else
                            pitch_reg <= 16'(32'(pitch_reg) + 32'(dyr));
                    end
                end
                efcu_pkg::CMD_WRAP:
                begin
                    if (wyaw_reg < 26'sd0) wyaw_reg <= wyaw_reg + 26'(efcu_pkg::YAW_FULL);
                    else if (wyaw_reg >= 26'(efcu_pkg::YAW_FULL))
                        wyaw_reg <= wyaw_reg - 26'(efcu_pkg::YAW_FULL);
                    else yaw_reg <= wyaw_reg[16:0];
                end
                efcu_pkg::CMD_CORDIC_INIT:
                begin
                    cx_reg <= efcu_pkg::CORDIC_GAIN; cy_reg <= '0; it_reg <= '0;
                    neg_reg <= 1'b0;
                    if (!cmd.second) cz_reg <= pang;
                    else if (yang > efcu_pkg::DEG270) cz_reg <= yang - efcu_pkg::DEG360;
                    else if (yang > efcu_pkg::DEG90) begin
                        cz_reg <= yang - efcu_pkg::DEG180; neg_reg <= 1'b1;
                    end else cz_reg <= yang;
                end
                efcu_pkg::CMD_CORDIC_STEP:
                begin
                    if (cz_reg >= 26'sd0) begin
                        cx_reg <= cx_reg - shx; cy_reg <= cy_reg + shy;
                        cz_reg <= cz_reg - 26'(efcu_pkg::atan_deg16(it_reg));
                    end else begin
                        cx_reg <= cx_reg + shx; cy_reg <= cy_reg - shy;
                        cz_reg <= cz_reg + 26'(efcu_pkg::atan_deg16(it_reg));
                    end
                    it_reg <= it_reg + 5'd1;
                end
                efcu_pkg::CMD_CORDIC_DONE:
                begin
                    if (!cmd.second) begin
                        sp_reg <= rs; cp_reg <= rc;
                    end else begin
                        sy_reg <= neg_reg ? -rs : rs;
                        cy2_reg <= neg_reg ? -rc : rc;
                    end
                    bstep_reg <= '0;
                end
                efcu_pkg::CMD_BUILD:
                begin
                    bstep_reg <= bstep_reg + 2'd1;
                    case (bstep_reg)
                        2'd0: prod_reg <= cp_reg * sy_reg;
                        2'd1:
                        begin
                            fx_reg <= 16'(-((prod_reg + 32'sd8192) >>> 14));
                            prod_reg <= cp_reg * cy2_reg;
                        end
                        default:
                        begin
                            fz_reg <= 16'(-((prod_reg + 32'sd8192) >>> 14));
                            fy_reg <= sp_reg;
                            sx_reg <= cy2_reg;
                            sz_reg <= -sy_reg;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
            if (cmd.wr_move) begin
                case (axis_reg)
                    2'd0: px_reg <= sat_p;
                    2'd1: py_reg <= sat_p;
                    default: pz_reg <= sat_p;
                endcase
                if (axis_reg == 2'd2) axis_reg <= 2'd0;
                else axis_reg <= dir_reg[1] ? 2'd2 : axis_reg + 2'd1;
            end
        end
    end

    assign pos_x = px_reg; assign pos_y = py_reg; assign pos_z = pz_reg;
    assign fwd_x = fx_reg; assign fwd_y = fy_reg; assign fwd_z = fz_reg;
    assign side_x = sx_reg; assign side_z = sz_reg;
    assign pitch_deg = pitch_reg; assign yaw_deg = yaw_reg;

endmodule
`default_nettype wire

// ===== hdl/efcu_control.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efcu_control: Fly-camera pose controller
// Sequences one item through load, move steps or the look path, then holds
// the result beat until it is taken.
// ----------------------------------------------------------------------------
module efcu_control (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire logic [1:0]        operation,
    input  wire logic [1:0]        move_direction,
    output efcu_pkg::dp_cmd_t      cmd,
    input  wire efcu_pkg::dp_status_t status
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_MOVE, S_SCALE, S_WRAP, S_CINIT, S_CSTEP, S_CDONE,
        S_BUILD, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] op_reg, cnt_reg, cnt_next;
    logic second_reg, second_next, side_reg;
    logic accept;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        second_next = second_reg;
        cmd = '{code: efcu_pkg::CMD_NONE, second: second_reg, wr_move: 1'b0,
                wr_set: 1'b0, wr_look: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    cmd.code = efcu_pkg::CMD_LOAD;
                    cmd.wr_set = (operation == efcu_pkg::OP_SET);
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cnt_next = '0;
                second_next = 1'b0;
                if (op_reg == efcu_pkg::OP_MOVE || op_reg == efcu_pkg::OP_LOOK)
                    state_next = S_SCALE;
                else
                    state_next = S_OUT;
            end
            S_SCALE:
            begin
                cmd.code = efcu_pkg::CMD_SCALE;
                cmd.wr_look = (op_reg == efcu_pkg::OP_LOOK);
                state_next = (op_reg == efcu_pkg::OP_MOVE) ? S_MOVE : S_WRAP;
            end
            S_MOVE:
            begin
                cmd.wr_move = 1'b1;
                cnt_next = cnt_reg + 2'd1;
                if ((side_reg && cnt_reg == 2'd1) || cnt_reg == 2'd2) state_next = S_OUT;
            end
            S_WRAP:
            begin
                cmd.code = efcu_pkg::CMD_WRAP;
                if (!status.wrap_busy) state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cmd.code = efcu_pkg::CMD_CORDIC_INIT;
                state_next = S_CSTEP;
            end
            S_CSTEP:
            begin
                cmd.code = efcu_pkg::CMD_CORDIC_STEP;
                if (status.cordic_last) state_next = S_CDONE;
            end
            S_CDONE:
            begin
                cmd.code = efcu_pkg::CMD_CORDIC_DONE;
                cnt_next = '0;
                if (second_reg) state_next = S_BUILD;
                else begin
                    second_next = 1'b1;
                    state_next = S_CINIT;
                end
            end
            S_BUILD:
            begin
                cmd.code = efcu_pkg::CMD_BUILD;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2) state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready) state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            op_reg <= '0;
            cnt_reg <= '0;
            second_reg <= 1'b0;
            side_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            second_reg <= second_next;
            if (accept) begin
                op_reg <= operation;
                side_reg <= move_direction[1];
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/euler_fly_camera_update.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_fly_camera_update: Fly-camera pose tracker
// Moves, turns and places a yaw/pitch camera and returns the full pose.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Contents
// in       input      in_valid / in_ready    operation and its operands
// out      output     out_valid / out_ready  position, vectors and angles
// cfg      input      cfg_we                 move_speed, look_sensitivity
//
// A set or unknown item goes straight from load to the result; a move steps the
// position axis by axis. A look item runs the shared CORDIC loop once for pitch
// and once for yaw, after yaw wrapping, which takes one extra turn for each
// further full circle to be wrapped.
// Reset gives the zero pose looking down negative z.
// The result beat holds while out_ready is low and no new item is taken.
// ----------------------------------------------------------------------------
module euler_fly_camera_update #(
    parameter int CORDIC_STEPS  = 16,
    parameter int POS_FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic [1:0]         move_direction,
    input  wire logic [15:0]        delta_time,
    input  wire logic signed [15:0] look_dx,
    input  wire logic signed [15:0] look_dy,
    input  wire logic signed [31:0] new_x,
    input  wire logic signed [31:0] new_y,
    input  wire logic signed [31:0] new_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      pos_z,
    output logic signed [15:0]      fwd_x,
    output logic signed [15:0]      fwd_y,
    output logic signed [15:0]      fwd_z,
    output logic signed [15:0]      side_x,
    output logic signed [15:0]      side_z,
    output logic signed [15:0]      pitch_deg,
    output logic [16:0]             yaw_deg,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data
);

    efcu_pkg::dp_cmd_t    cmd;
    efcu_pkg::dp_status_t status;

    efcu_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .operation(operation),
        .move_direction(move_direction), .cmd(cmd), .status(status)
    );

    efcu_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .POS_FRAC_BITS(POS_FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .move_direction(move_direction), .delta_time(delta_time),
        .look_dx(look_dx), .look_dy(look_dy),
        .new_x(new_x), .new_y(new_y), .new_z(new_z),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
        .side_x(side_x), .side_z(side_z),
        .pitch_deg(pitch_deg), .yaw_deg(yaw_deg)
    );

endmodule
`default_nettype wire

// ===== hdl/efcu_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efcu_checker: Fly-camera port checker
// Watches the ports of the top level for handshake and range slips.
// ----------------------------------------------------------------------------
module efcu_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic signed [15:0] pitch_deg,
    input wire logic [16:0]       yaw_deg
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(yaw_deg))
        else $error("result beat dropped while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result waits");

    a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        pitch_deg <= 16'sd22784 && pitch_deg >= -16'sd22784)
        else $error("pitch out of range");

    a_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        yaw_deg < 17'd92160)
        else $error("yaw out of range");

endmodule

bind euler_fly_camera_update efcu_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .pitch_deg(pitch_deg), .yaw_deg(yaw_deg)
);
`default_nettype wire
